// ----- rtl/mmtd_pkg.sv -----
// Shared types, constants and character decode functions for the multi-mode
// text decoder. No dependencies; every other rtl file imports this package.
package mmtd_pkg;

   localparam int unsigned JOB_DEPTH_DEF = 4;
   localparam int unsigned HELD_W        = 18;
   localparam int unsigned MAX_BYTES     = 3;

   localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

   typedef enum logic [1:0] {
      MODE_HEX   = 2'd0,
      MODE_B64   = 2'd1,
      MODE_ROT13 = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic       last_in_run;
      logic       end_of_string;
      logic       bad_input;
   } rsp_type;

   // One decoded character's worth of results, handed from front to back.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] data;
      logic [1:0]                num_res;   // 1..3 results
      logic                      has_data;
      logic                      end_str;
      logic                      bad;
   } job_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] res;
      res = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         res = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         res = {1'b1, c[3:0] + 4'd9};
      end
      return res;
   endfunction

   // {valid, 6-bit symbol value}
   function automatic logic [6:0] b64_symbol(input logic [7:0] c);
      logic [7:0] tmp;
      logic [6:0] res;
      tmp = 8'd0;
      res = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         tmp = c - 8'd65;
         res = {1'b1, tmp[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         tmp = c - 8'd71;
         res = {1'b1, tmp[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         tmp = c + 8'd4;
         res = {1'b1, tmp[5:0]};
      end else if (c == 8'h2B) begin
         res = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         res = {1'b1, 6'd63};
      end
      return res;
   endfunction

   function automatic logic [7:0] rot13(input logic [7:0] c);
      logic [7:0] res;
      res = c;
      if ((c >= 8'h61 && c <= 8'h6D) || (c >= 8'h41 && c <= 8'h4D)) begin
         res = c + 8'd13;
      end else if ((c >= 8'h6E && c <= 8'h7A) || (c >= 8'h4E && c <= 8'h5A)) begin
         res = c - 8'd13;
      end
      return res;
   endfunction

endpackage

// ----- rtl/multi_mode_text_decoder.sv -----
// Multi-mode text decoder (hex pairs, base64, rot13) with queue-style ports.
// The input side takes one character per cycle whenever req_full is low; the
// decode and group update for a character complete in the cycle it is
// accepted, and its results (none, one, or up to three bytes for a full
// base64 group) go into a JOB_DEPTH-entry job queue. The result side drains
// that queue at one result per cycle while rsp_pop is high; a job shows only
// once it is registered in the queue. Sustained input rate is one character
// per cycle for all modes while the consumer keeps up. In any mode a slow
// consumer fills the JOB_DEPTH jobs and raises req_full. A full queue refuses
// a character even in the cycle that pops the last result of a job.
// Depends on mmtd_pkg, mmtd_front, mmtd_job_fifo and mmtd_back.
module multi_mode_text_decoder #(
   parameter int unsigned JOB_DEPTH = mmtd_pkg::JOB_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mmtd_pkg::req_type req_word,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mmtd_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_wdata
);
   import mmtd_pkg::*;

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_wdata, job_rdata;

   mmtd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .job_push  (job_push),
      .job_word  (job_wdata),
      .job_full  (job_full)
   );

   mmtd_job_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .job_push  (job_push),
      .job_wdata (job_wdata),
      .job_full  (job_full),
      .job_pop   (job_pop),
      .job_rdata (job_rdata),
      .job_empty (job_empty)
   );

   mmtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_rdata (job_rdata),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- rtl/mmtd_front.sv -----
// Front end: mode register, per-character decode and group state.
// Builds one job per character that yields results or ends a string. Depends on mmtd_pkg.
module mmtd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mmtd_pkg::req_type req_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_wdata,
   output logic              job_push,
   output mmtd_pkg::job_type job_word,
   input  logic              job_full
);
   import mmtd_pkg::*;

   mode_type            mode_ff;
   logic [1:0]          gp_ff, gp_in, gp_step;
   logic [HELD_W-1:0]   held_ff, held_in, held_step;
   logic                err_ff, err_in, err_step;
   logic                pad3_ff, pad3_in, pad3_step;

   logic                accept;
   logic [4:0]          hex_res;
   logic [6:0]          b64_res;
   logic [5:0]          b64_val;
   logic [23:0]         b64_word;
   logic                is_pad;
   logic [MAX_BYTES-1:0][7:0] out_data;
   logic [1:0]          n_res;
   logic                bad_final;

   assign csr_ready = 1'b1;
   assign req_full  = job_full;
   assign accept    = req_push && !job_full;

   always_comb begin
      hex_res   = hex_digit(req_word.in_char);
      b64_res   = b64_symbol(req_word.in_char);
      is_pad    = (req_word.in_char == CHAR_PAD);
      b64_val   = is_pad ? 6'd0 : b64_res[5:0];
      b64_word  = {held_ff, b64_val};
      gp_step   = gp_ff;
      held_step = held_ff;
      err_step  = err_ff;
      pad3_step = pad3_ff;
      out_data  = '0;
      n_res     = 2'd0;
      unique case (mode_ff)
         MODE_HEX: begin
            if (!hex_res[4]) err_step = 1'b1;
            if (gp_ff == 2'd0) begin
               held_step = {{(HELD_W-4){1'b0}}, hex_res[3:0]};
               gp_step   = 2'd1;
            end else begin
               // any nonzero position counts as the low digit
               out_data[0] = {held_ff[3:0], hex_res[3:0]};
               n_res       = 2'd1;
               held_step   = '0;
               gp_step     = 2'd0;
            end
         end
         MODE_B64: begin
            if ((!is_pad && !b64_res[6]) || (is_pad && gp_ff < 2'd2)) err_step = 1'b1;
            if (gp_ff != 2'd3) begin
               if (gp_ff == 2'd2) pad3_step = is_pad;
               held_step = {held_ff[HELD_W-7:0], b64_val};
               gp_step   = gp_ff + 2'd1;
            end else begin
               out_data[0] = b64_word[23:16];
               if (pad3_ff) begin
                  if (!is_pad) err_step = 1'b1;
                  n_res = 2'd1;
               end else begin
                  out_data[1] = b64_word[15:8];
                  if (is_pad) begin
                     n_res = 2'd2;
                  end else begin
                     out_data[2] = b64_word[7:0];
                     n_res       = 2'd3;
                  end
               end
               held_step = '0;
               gp_step   = 2'd0;
               pad3_step = 1'b0;
            end
         end
         MODE_ROT13: begin
            out_data[0] = rot13(req_word.in_char);
            n_res       = 2'd1;
         end
         MODE_RSVD: begin
            err_step = 1'b1;
         end
         default: begin
            err_step = 1'b1;
         end
      endcase
      // a partial group at end of string is dropped and flagged
      bad_final = err_step ||
                  ((mode_ff == MODE_HEX || mode_ff == MODE_B64) && gp_step != 2'd0);
   end

   always_comb begin
      gp_in   = gp_ff;
      held_in = held_ff;
      err_in  = err_ff;
      pad3_in = pad3_ff;
      if (accept) begin
         if (req_word.last_char) begin
            gp_in   = 2'd0;
            held_in = '0;
            err_in  = 1'b0;
            pad3_in = 1'b0;
         end else begin
            gp_in   = gp_step;
            held_in = held_step;
            err_in  = err_step;
            pad3_in = pad3_step;
         end
      end
   end

   always_comb begin
      job_push          = accept && (n_res != 2'd0 || req_word.last_char);
      job_word.data     = out_data;
      job_word.num_res  = (n_res != 2'd0) ? n_res : 2'd1;
      job_word.has_data = (n_res != 2'd0);
      job_word.end_str  = req_word.last_char;
      job_word.bad      = req_word.last_char && bad_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HEX;
         gp_ff   <= 2'd0;
         held_ff <= '0;
         err_ff  <= 1'b0;
         pad3_ff <= 1'b0;
      end else begin
         if (csr_valid) mode_ff <= mode_type'(csr_wdata);
         gp_ff   <= gp_in;
         held_ff <= held_in;
         err_ff  <= err_in;
         pad3_ff <= pad3_in;
      end
   end

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.last_char |=> gp_ff == 2'd0 && !err_ff && !pad3_ff)
      else $error("group state not cleared after end of string");

   a_last_makes_job: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.last_char |-> job_push && job_word.end_str)
      else $error("end of string produced no job");

endmodule

// ----- rtl/mmtd_job_fifo.sv -----
// Small job queue between front and back ends.
// Depends on mmtd_pkg for the job word type.
module mmtd_job_fifo #(
   parameter int unsigned DEPTH = mmtd_pkg::JOB_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_push,
   input  mmtd_pkg::job_type job_wdata,
   output logic              job_full,
   input  logic              job_pop,
   output mmtd_pkg::job_type job_rdata,
   output logic              job_empty
);
   import mmtd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign job_full  = (count_ff == CNT_W'(DEPTH));
   assign job_empty = (count_ff == '0);
   assign do_push   = job_push && !job_full;
   assign do_pop    = job_pop && !job_empty;
   assign job_rdata = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= job_wdata;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue count overflow");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      job_full |-> !job_push)
      else $error("job pushed into full queue");

endmodule

// ----- rtl/mmtd_back.sv -----
// Back end: walks the head job one result per cycle onto the result port while rsp_pop is high.
// Depends on mmtd_pkg.
module mmtd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  mmtd_pkg::job_type job_rdata,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mmtd_pkg::rsp_type rsp_word
);
   import mmtd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       head_last;
   logic       take;

   assign rsp_empty = job_empty;
   assign take      = rsp_pop && !job_empty;
   assign head_last = (idx_ff == job_rdata.num_res - 2'd1);
   assign job_pop   = take && head_last;

   always_comb begin
      unique case (idx_ff)
         2'd0:    rsp_word.data_byte = job_rdata.data[0];
         2'd1:    rsp_word.data_byte = job_rdata.data[1];
         2'd2:    rsp_word.data_byte = job_rdata.data[2];
         default: rsp_word.data_byte = 8'd0;
      endcase
      rsp_word.has_data      = job_rdata.has_data;
      rsp_word.last_in_run   = head_last;
      rsp_word.end_of_string = job_rdata.end_str && head_last;
      rsp_word.bad_input     = job_rdata.bad && head_last;
   end

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = head_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !job_empty |-> idx_ff < job_rdata.num_res)
      else $error("result index beyond job size");

   a_job_continues: assert property (@(posedge clock) disable iff (reset)
      take && !head_last |=> !rsp_empty && idx_ff != 2'd0)
      else $error("job dropped before its last result");

endmodule

// ----- bench/mmtd_checker.sv -----
// Response checker for the multi-mode text decoder: tracks csr writes, predicts
// the response words of every accepted character and compares them in order.
// Depends on mmtd_pkg for the word types, mode codes and the pad character.
module mmtd_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  mmtd_pkg::req_type req_word,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  mmtd_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_wdata,
   output int                fail_count,
   output int                words_due
);
   import mmtd_pkg::*;

   mode_type    cur_mode;
   logic [1:0]  group_pos;
   logic [17:0] held_syms;
   logic        saw_error;
   logic        third_was_pad;
   rsp_type     due_words[$];
   int          mismatches = 0;

   assign fail_count = mismatches;

   // {ok, value}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] res;
      res = '0;
      if (c >= "0" && c <= "9") begin
         res = {1'b1, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         res = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         res = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return res;
   endfunction

   // {ok, value}
   function automatic logic [6:0] b64_value(input logic [7:0] c);
      logic [6:0] res;
      res = '0;
      if (c >= "A" && c <= "Z") begin
         res = {1'b1, 6'(c - "A")};
      end else if (c >= "a" && c <= "z") begin
         res = {1'b1, 6'(c - "a" + 8'd26)};
      end else if (c >= "0" && c <= "9") begin
         res = {1'b1, 6'(c - "0" + 8'd52)};
      end else if (c == "+") begin
         res = {1'b1, 6'd62};
      end else if (c == "/") begin
         res = {1'b1, 6'd63};
      end
      return res;
   endfunction

   function automatic logic [7:0] rotate13(input logic [7:0] c);
      int ci;
      ci = c;
      if (ci >= 97 && ci <= 122) begin
         ci = (ci - 97 + 13) % 26 + 97;
      end else if (ci >= 65 && ci <= 90) begin
         ci = (ci - 65 + 13) % 26 + 65;
      end
      return 8'(ci);
   endfunction

   task automatic predict_decode(input req_type w);
      logic [7:0]  out_bytes[3];
      int          n;
      int          k;
      logic [4:0]  nib;
      logic [6:0]  sym;
      logic [5:0]  v;
      logic        pad;
      logic [23:0] grp;
      rsp_type     r;
      n = 0;
      case (cur_mode)
         MODE_HEX: begin
            nib = hex_nibble(w.in_char);
            if (!nib[4]) saw_error = 1'b1;
            // any nonzero position counts as the low digit, even after a mode change
            if (group_pos == 2'd0) begin
               held_syms = {14'd0, nib[3:0]};
               group_pos = 2'd1;
            end else begin
               out_bytes[n] = {held_syms[3:0], nib[3:0]};
               n++;
               held_syms = '0;
               group_pos = 2'd0;
            end
         end
         MODE_B64: begin
            pad = (w.in_char == CHAR_PAD);
            sym = b64_value(w.in_char);
            v = pad ? 6'd0 : sym[5:0];
            if (!pad && !sym[6]) saw_error = 1'b1;
            if (pad && group_pos < 2'd2) saw_error = 1'b1;
            if (group_pos < 2'd3) begin
               if (group_pos == 2'd2) third_was_pad = pad;
               held_syms = {held_syms[11:0], v};
               group_pos = group_pos + 2'd1;
            end else begin
               grp = {held_syms, v};
               out_bytes[n] = grp[23:16];
               n++;
               if (third_was_pad) begin
                  if (!pad) saw_error = 1'b1;
               end else begin
                  out_bytes[n] = grp[15:8];
                  n++;
                  if (!pad) begin
                     out_bytes[n] = grp[7:0];
                     n++;
                  end
               end
               held_syms = '0;
               group_pos = 2'd0;
               third_was_pad = 1'b0;
            end
         end
         MODE_ROT13: begin
            out_bytes[n] = rotate13(w.in_char);
            n++;
         end
         default: begin
            saw_error = 1'b1;
         end
      endcase

      // a group left open at end of string is dropped
      if (w.last_char && (cur_mode == MODE_HEX || cur_mode == MODE_B64) && group_pos != 2'd0)
         saw_error = 1'b1;

      if (n == 0 && w.last_char) begin
         r = '0;
         r.last_in_run   = 1'b1;
         r.end_of_string = 1'b1;
         r.bad_input     = saw_error;
         due_words.push_back(r);
      end
      for (k = 0; k < n; k++) begin
         r = '0;
         r.data_byte     = out_bytes[k];
         r.has_data      = 1'b1;
         r.last_in_run   = (k == n - 1);
         r.end_of_string = w.last_char && (k == n - 1);
         r.bad_input     = w.last_char && (k == n - 1) && saw_error;
         due_words.push_back(r);
      end

      if (w.last_char) begin
         group_pos     = 2'd0;
         held_syms     = '0;
         saw_error     = 1'b0;
         third_was_pad = 1'b0;
      end
   endtask

   task automatic compare_word(input rsp_type got);
      rsp_type want;
      if (due_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response word %h with none expected", $realtime, got);
      end else begin
         want = due_words.pop_front();
         if (got.data_byte !== want.data_byte || got.has_data !== want.has_data ||
             got.last_in_run !== want.last_in_run ||
             got.end_of_string !== want.end_of_string || got.bad_input !== want.bad_input) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: expected data %h has %b run %b eos %b bad %b, got %h %b %b %b %b",
                        $realtime, want.data_byte, want.has_data, want.last_in_run,
                        want.end_of_string, want.bad_input, got.data_byte, got.has_data,
                        got.last_in_run, got.end_of_string, got.bad_input);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cur_mode      = MODE_HEX;
         group_pos     = 2'd0;
         held_syms     = '0;
         saw_error     = 1'b0;
         third_was_pad = 1'b0;
         due_words.delete();
      end else begin
         // responses first: a word pushed at this edge cannot pop before the next
         if (rsp_pop && !rsp_empty) compare_word(rsp_word);
         if (csr_valid && csr_ready) cur_mode = mode_type'(csr_wdata);
         if (req_push && !req_full) predict_decode(req_word);
      end
      words_due <= due_words.size();
   end

endmodule

// ----- bench/multi_mode_text_decoder_test.sv -----
// Testbench top for the multi-mode text decoder: drives characters, pops and
// csr writes with random stalls; checking is done by mmtd_checker.
// Depends on mmtd_pkg, mmtd_checker and the decoder rtl.
module multi_mode_text_decoder_test;
   import mmtd_pkg::*;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_push  = 1'b0;
   req_type    req_word  = '0;
   logic       rsp_pop   = 1'b0;
   logic       csr_valid = 1'b0;
   logic [1:0] csr_wdata = 2'd0;
   logic       req_full;
   logic       rsp_empty;
   logic       csr_ready;
   rsp_type    rsp_word;
   int         fail_count;
   int         words_due;

   mode_type   cur_mode = MODE_HEX;
   bit         feed_burst = 1'b0;
   bit         drain_burst = 1'b0;
   int         chars_sent = 0;

   multi_mode_text_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   mmtd_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_word   (req_word),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [7:0] hex_char(input int v);
      if (v < 10) return 8'("0" + v);
      return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   function automatic logic [7:0] b64_char(input int v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      return (v == 62) ? 8'("+") : 8'("/");
   endfunction

   task automatic send_char(input logic [7:0] c, input logic last);
      int      gap;
      req_type w;
      if ($urandom_range(0, 15) == 0) feed_burst = !feed_burst;
      gap = feed_burst ? 0 : $urandom_range(0, 17);
      w.in_char   = c;
      w.last_char = last;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // push stays high so back-to-back words need no gap
      req_push <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_full);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input bit end_it);
      int i;
      for (i = 0; i < s.len(); i++) send_char(s[i], end_it && (i == s.len() - 1));
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   task automatic set_mode(input mode_type m);
      wait_drained();
      // a character with no response may still be in flight
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_mode = m;
   endtask

   task automatic send_random_string(input mode_type m);
      logic [7:0] text[$];
      int         i;
      int         len;
      int         pads;
      bit         unfinished;
      case (m)
         MODE_HEX: begin
            len = 2 * $urandom_range(1, 4);
            for (i = 0; i < len; i++) text.push_back(hex_char($urandom_range(0, 15)));
            if ($urandom_range(0, 7) == 0) void'(text.pop_back());
         end
         MODE_B64: begin
            len = 4 * $urandom_range(1, 3);
            for (i = 0; i < len; i++) text.push_back(b64_char($urandom_range(0, 63)));
            pads = $urandom_range(0, 2);
            for (i = 0; i < pads; i++) text[len - 1 - i] = CHAR_PAD;
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 3)) void'(text.pop_back());
         end
         MODE_ROT13: begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 1))
                  text.push_back(8'($urandom_range(0, 255)));
               else
                  text.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25)));
            end
         end
         default: begin
            len = $urandom_range(1, 2);
            for (i = 0; i < len; i++) text.push_back(8'($urandom_range(0, 255)));
         end
      endcase
      for (i = 0; i < text.size(); i++)
         if ($urandom_range(0, 19) == 0)
            text[i] = ($urandom_range(0, 2) == 0) ? CHAR_PAD : 8'($urandom_range(0, 255));
      // now and then leave the string open across the next mode change
      unfinished = ($urandom_range(0, 9) == 0);
      for (i = 0; i < text.size(); i++)
         send_char(text[i], !unfinished && (i == text.size() - 1));
   endtask

   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) drain_burst = !drain_burst;
         gap = drain_burst ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   initial begin
      int first_random;
      int pick;
      int spins;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hex: a good pair, a bad digit, trailing half pair
      set_mode(MODE_HEX);
      send_text("0Fag7", 1'b1);
      // base64: full group, misplaced pad and bad symbol, non-pad after third pad
      set_mode(MODE_B64);
      send_text("+/9z=*A=Zg=x", 1'b1);
      set_mode(MODE_ROT13);
      send_char(8'h00, 1'b0);
      send_text("AzMn", 1'b0);
      send_char(8'hFF, 1'b1);
      set_mode(MODE_RSVD);
      send_char("Q", 1'b1);
      // mode change with a base64 symbol held
      set_mode(MODE_B64);
      send_text("Q", 1'b0);
      set_mode(MODE_HEX);
      send_char("5", 1'b1);

      first_random = chars_sent;
      while (chars_sent - first_random < 195) begin
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 12);
            set_mode((pick == 12) ? MODE_RSVD : mode_type'(pick % 3));
         end
         send_random_string(cur_mode);
         if ($urandom_range(0, 14) == 0) wait_drained();
      end

      req_push <= 1'b0;
      spins = 0;
      do begin
         @(posedge clock);
         spins++;
      end while (words_due != 0 && spins < 4000);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && words_due == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
